FILE: src/lct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lct_pkg
// Shared types and constants of the LRU cache table.
// ----------------------------------------------------------------------------
package lct_pkg;

  localparam int unsigned EntriesDef   = 16;
  localparam int unsigned KeyBitsDef   = 64;
  localparam int unsigned ValueBitsDef = 32;
  localparam int unsigned CapW         = 5;
  localparam int unsigned KindW        = 2;

  localparam logic [KindW-1:0] KIND_LOOKUP = 2'd0;
  localparam logic [KindW-1:0] KIND_INSERT = 2'd1;
  localparam logic [KindW-1:0] KIND_ERASE  = 2'd2;
  localparam logic [KindW-1:0] KIND_NONE   = 2'd3;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [63:0]      key;
    logic [31:0]      value;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] value_out;
  } rsp_t;

endpackage

FILE: src/lct_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lct_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lct_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: src/lru_cache_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_cache_table_unit
// Fully associative cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Each operation scans live entries in recency order, alternating a read
// state (ST_SCAN) and a compare state (ST_CMP): a hit ends in ST_CMP, a miss
// in ST_SCAN at the occupancy, kind 3 in ST_SCAN with no scan. One operation
// at a time; a stalled output holds the final state. Reset empties the cache
// at once (no clearing pass) and sets capacity to the entry count.
module lru_cache_table_unit #(
  parameter int unsigned ENTRIES    = lct_pkg::EntriesDef,
  parameter int unsigned KEY_BITS   = lct_pkg::KeyBitsDef,
  parameter int unsigned VALUE_BITS = lct_pkg::ValueBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  lct_pkg::req_t             in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output lct_pkg::rsp_t             out_data_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [lct_pkg::CapW-1:0]  cfg_data_i
);

  localparam int unsigned IdxW = $clog2(ENTRIES);
  localparam int unsigned OccW = $clog2(ENTRIES + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_CMP  = 2'd2;

  logic [1:0]               state_q, state_d;
  logic [OccW-1:0]          p_q, p_d, occ_q, occ_d;
  logic [IdxW-1:0]          order_q [ENTRIES];
  logic [IdxW-1:0]          order_d [ENTRIES];
  logic [lct_pkg::CapW-1:0] cap_q;
  lct_pkg::req_t            req_q, req_d;
  logic                     out_valid_q;
  lct_pkg::rsp_t            out_q, rsp;

  logic                     out_free, fin;
  logic [IdxW-1:0]          p_idx, rd_slot, ins_slot, front_pos;
  logic [OccW-1:0]          cap_eff, occ_ins;
  logic                     do_front, do_remove;
  logic [KEY_BITS-1:0]      key_k, key_rd;
  logic [VALUE_BITS-1:0]    val_v, val_rd;
  logic [63:0]              v64, rd64;
  logic                     kwe, vwe;
  logic [IdxW-1:0]          waddr;

  assign p_idx   = p_q[IdxW-1:0];
  assign rd_slot = order_q[p_idx];
  assign key_k   = req_q.key[KEY_BITS-1:0];
  assign v64     = 64'(req_q.value) & ((64'(1) << VALUE_BITS) - 64'(1));
  assign val_v   = v64[VALUE_BITS-1:0];
  assign rd64    = 64'(val_rd);

  // capacity clamped to 1..ENTRIES
  always_comb begin
    if (cap_q == '0) begin
      cap_eff = OccW'(1);
    end else if (32'(cap_q) > ENTRIES) begin
      cap_eff = OccW'(ENTRIES);
    end else begin
      cap_eff = OccW'(cap_q);
    end
  end

  assign occ_ins  = (occ_q >= cap_eff) ? cap_eff - OccW'(1) : occ_q;
  assign ins_slot = order_q[occ_ins[IdxW-1:0]];
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d   = state_q;
    p_d       = p_q;
    occ_d     = occ_q;
    req_d     = req_q;
    fin       = 1'b0;
    rsp       = '0;
    do_front  = 1'b0;
    do_remove = 1'b0;
    front_pos = p_idx;
    kwe       = 1'b0;
    vwe       = 1'b0;
    waddr     = rd_slot;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_data_i;
          p_d     = '0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (req_q.kind == lct_pkg::KIND_NONE) begin
          fin = out_free;
        end else if (p_q >= occ_q) begin
          // miss
          fin = out_free;
          if (req_q.kind == lct_pkg::KIND_INSERT) begin
            rsp.value_out = v64[31:0];
            if (out_free) begin
              kwe       = 1'b1;
              vwe       = 1'b1;
              waddr     = ins_slot;
              do_front  = 1'b1;
              front_pos = occ_ins[IdxW-1:0];
              occ_d     = occ_ins + OccW'(1);
            end
          end
        end else begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        if (key_rd == key_k) begin
          fin     = out_free;
          rsp.hit = 1'b1;
          if (out_free) begin
            unique case (req_q.kind)
              lct_pkg::KIND_LOOKUP: begin
                rsp.value_out = rd64[31:0];
                do_front      = 1'b1;
              end
              lct_pkg::KIND_INSERT: begin
                rsp.value_out = v64[31:0];
                vwe           = 1'b1;
                do_front      = 1'b1;
              end
              default: begin
                do_remove = 1'b1;
                occ_d     = occ_q - OccW'(1);
              end
            endcase
          end
        end else begin
          p_d     = p_q + OccW'(1);
          state_d = ST_SCAN;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (fin) begin
      state_d = ST_IDLE;
    end
  end

  // recency list update: move to front, or remove and park slot at the tail
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      order_d[i] = order_q[i];
      if (do_front) begin
        if (i == 0) begin
          order_d[i] = order_q[front_pos];
        end else if (IdxW'(i) <= front_pos) begin
          order_d[i] = order_q[i-1];
        end
      end else if (do_remove) begin
        if (i == ENTRIES - 1) begin
          order_d[i] = order_q[p_idx];
        end else if (IdxW'(i) >= p_idx) begin
          order_d[i] = order_q[i+1];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      p_q         <= '0;
      occ_q       <= '0;
      cap_q       <= lct_pkg::CapW'(ENTRIES & 31);
      out_valid_q <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        order_q[i] <= IdxW'(i);
      end
    end else begin
      state_q <= state_d;
      p_q     <= p_d;
      occ_q   <= occ_d;
      order_q <= order_d;
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
      if (fin) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    if (fin) begin
      out_q <= rsp;
    end
  end

  lct_ram #(.Width(KEY_BITS), .Depth(ENTRIES)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (kwe),
    .waddr_i (waddr),
    .wdata_i (key_k),
    .raddr_i (rd_slot),
    .rdata_o (key_rd)
  );

  lct_ram #(.Width(VALUE_BITS), .Depth(ENTRIES)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (vwe),
    .waddr_i (waddr),
    .wdata_i (val_v),
    .raddr_i (rd_slot),
    .rdata_o (val_rd)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OccW'(ENTRIES)) else $error("occupancy above entry count");
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CMP |-> p_q < occ_q) else $error("compare beyond live entries");
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) != ST_IDLE) else $error("result without operation");
  a_occ_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q != $past(occ_q) |-> $past(fin)) else $error("occupancy changed mid-operation");
`endif

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the LRU cache table against a behavioural model of its entry list:
// directed lookups, inserts, erases and capacity changes, then random
// traffic over small key pools under varying idle and stall patterns.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned NumSlots   = 16;
  localparam int unsigned CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  lct_pkg::req_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  lct_pkg::rsp_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [lct_pkg::CapW-1:0] cfg_data_i = '0;

  lru_cache_table_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // model state: live entries held most recent first
  logic [63:0] lru_keys[$];
  logic [31:0] lru_vals[$];
  int unsigned cap_limit = NumSlots;
  lct_pkg::rsp_t pending_rsp[$];
  int unsigned err_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  bit          hold_off = 1'b0;
  int unsigned cycle_count = 0;
  logic [63:0] key_pool[8];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    err_count++;
  endtask

  function automatic lct_pkg::rsp_t predict_access(input lct_pkg::req_t req);
    lct_pkg::rsp_t r;
    int   pos;
    logic [31:0] v;
    r = '0;
    pos = -1;
    foreach (lru_keys[i]) if (pos < 0 && lru_keys[i] == req.key) pos = i;
    if (req.kind == lct_pkg::KIND_NONE) return r;
    r.hit = (pos >= 0);
    case (req.kind)
      lct_pkg::KIND_LOOKUP: begin
        if (pos >= 0) begin
          v = lru_vals[pos];
          r.value_out = v;
          lru_keys.delete(pos); lru_vals.delete(pos);
          lru_keys.push_front(req.key); lru_vals.push_front(v);
        end
      end
      lct_pkg::KIND_INSERT: begin
        if (pos >= 0) begin
          lru_keys.delete(pos); lru_vals.delete(pos);
        end else begin
          // drop least recent entries until the new key fits
          while (lru_keys.size() >= cap_limit) begin
            lru_keys.delete(lru_keys.size() - 1);
            lru_vals.delete(lru_vals.size() - 1);
          end
        end
        lru_keys.push_front(req.key); lru_vals.push_front(req.value);
        r.value_out = req.value;
      end
      lct_pkg::KIND_ERASE: begin
        if (pos >= 0) begin
          lru_keys.delete(pos); lru_vals.delete(pos);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // valid stays high on return; drain_wait or a later idle gap lowers it
  task automatic send_op(input logic [lct_pkg::KindW-1:0] kind, input logic [63:0] key,
                         input logic [31:0] value);
    lct_pkg::req_t req;
    req.kind = kind; req.key = key; req.value = value;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_data_i  <= req;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_rsp.push_back(predict_access(req));
    @(negedge clk_i);
  endtask

  task automatic drain_wait();
    in_valid_i <= 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk_i);
    repeat (2 * NumSlots + 8) @(negedge clk_i);
  endtask

  task automatic write_capacity(input logic [lct_pkg::CapW-1:0] cap);
    drain_wait();
    cfg_data_i  <= cap;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cap_limit = (cap == 0) ? 1 : (cap > NumSlots) ? NumSlots : cap;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // result checker
  always @(posedge clk_i) begin
    lct_pkg::rsp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_rsp.size() == 0) begin
        report_mismatch("unexpected transaction", out_data_o.value_out, '0);
      end else begin
        want = pending_rsp.pop_front();
        if (out_data_o.hit !== want.hit)
          report_mismatch("hit", 32'(out_data_o.hit), 32'(want.hit));
        if (out_data_o.value_out !== want.value_out)
          report_mismatch("value_out", out_data_o.value_out, want.value_out);
      end
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= !hold_off && ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("FAIL lru_cache_table_unit");
      $finish;
    end
  end

  task automatic test_basic_ops();
    send_op(lct_pkg::KIND_LOOKUP, 64'h0, 32'h0);
    send_op(lct_pkg::KIND_INSERT, 64'h0, 32'hFFFF_FFFF);
    send_op(lct_pkg::KIND_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
    send_op(lct_pkg::KIND_LOOKUP, 64'h0, 32'h1234);
    send_op(lct_pkg::KIND_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
    send_op(lct_pkg::KIND_INSERT, 64'h0, 32'hA5A5_5A5A);
    send_op(lct_pkg::KIND_LOOKUP, 64'h0, 32'h0);
    send_op(lct_pkg::KIND_NONE, 64'h0, 32'hFFFF_FFFF);
    send_op(lct_pkg::KIND_ERASE, 64'h0, 32'h5);
    send_op(lct_pkg::KIND_ERASE, 64'h0, 32'h0);
    send_op(lct_pkg::KIND_LOOKUP, 64'h0, 32'h0);
    send_op(lct_pkg::KIND_LOOKUP, 64'h1, 32'h0);
  endtask

  task automatic test_capacity_edges();
    write_capacity(5'd1);
    send_op(lct_pkg::KIND_INSERT, 64'h10, 32'h10);
    send_op(lct_pkg::KIND_INSERT, 64'h11, 32'h11);
    send_op(lct_pkg::KIND_LOOKUP, 64'h10, 32'h0);
    write_capacity(5'd0);
    send_op(lct_pkg::KIND_INSERT, 64'h12, 32'h12);
    write_capacity(5'd31);
    for (int i = 0; i < 17; i++)
      send_op(lct_pkg::KIND_INSERT, 64'h100 + 64'(i), 32'(i));
    send_op(lct_pkg::KIND_LOOKUP, 64'h100, 32'h0);
    send_op(lct_pkg::KIND_LOOKUP, 64'h101, 32'h0);
    // lowering capacity evicts only on the next new insert
    write_capacity(5'd3);
    send_op(lct_pkg::KIND_LOOKUP, 64'h105, 32'h0);
    send_op(lct_pkg::KIND_INSERT, 64'h200, 32'h200);
    send_op(lct_pkg::KIND_LOOKUP, 64'h110, 32'h0);
    write_capacity(5'd16);
  endtask

  task automatic random_traffic(input int unsigned n, input int unsigned pool);
    logic [lct_pkg::KindW-1:0] kind;
    logic [63:0] key;
    int unsigned r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      kind = (r < 40) ? lct_pkg::KIND_LOOKUP : (r < 80) ? lct_pkg::KIND_INSERT :
             (r < 95) ? lct_pkg::KIND_ERASE : lct_pkg::KIND_NONE;
      key = ($urandom_range(9) == 0) ? {$urandom, $urandom}
                                     : key_pool[$urandom_range(pool - 1)];
      send_op(kind, key, $urandom);
    end
  endtask

  task automatic test_random_phases();
    logic [lct_pkg::CapW-1:0] caps[5] = '{5'd16, 5'd4, 5'd1, 5'd31, 5'd9};
    int unsigned idle_s[4] = '{0, 72, 0, 34};
    int unsigned idle_r[4] = '{0, 0, 72, 34};
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    for (int p = 0; p < 5; p++) begin
      write_capacity(caps[p]);
      send_idle_pct = idle_s[p % 4];
      stall_pct     = idle_r[p % 4];
      random_traffic(90, (p == 2) ? 3 : 8);
    end
    send_idle_pct = 0; stall_pct = 0;
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(negedge clk_i);
        hold_off = 1'b0;
      end
      random_traffic(30, 8);
    join
    drain_wait();
    random_traffic(10, 8);
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    test_basic_ops();
    test_capacity_edges();
    test_random_phases();
    test_backpressure();
    drain_wait();
    if (err_count == 0) $display("PASS lru_cache_table_unit");
    else $display("FAIL lru_cache_table_unit");
    $finish;
  end

endmodule

FILE: lru_cache_table_unit.f
src/lct_pkg.sv
src/lct_ram.sv
src/lru_cache_table_unit.sv
bench/testbench.sv
